// File: hw/rtl/itlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itlp_pkg
// shared types and constants of the ipv4 text line parser
// ----------------------------------------------------------------------------
package itlp_pkg;

    localparam int CH_W       = 8;
    localparam int LEN_W      = 12;
    localparam int ADDR_W     = 32;
    localparam int STAT_W     = 2;
    localparam int MAX_DIGITS = 31;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(256);

    // special bytes
    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE = 8'h39;
    localparam logic [CH_W-1:0] CH_TAB  = 8'h09;
    localparam logic [CH_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CH_W-1:0] CH_SP   = 8'h20;

    // field packing shifts
    localparam int SH_F1 = 24;
    localparam int SH_F2 = 16;
    localparam int SH_F3 = 8;

    typedef enum logic [2:0] {
        PH_DONE = 3'd0,
        PH_SKIP = 3'd1,
        PH_F1   = 3'd2,
        PH_F2   = 3'd3,
        PH_F3   = 3'd4,
        PH_F4   = 3'd5
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_IGNORE  = 2'd2
    } t_status;

    // registered input word handed to the parse core
    typedef struct packed {
        logic            vld;
        logic [CH_W-1:0] ch;
        logic            first_of_line;
    } t_byte_word;

    // registered result handed back to the output channel
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] address;
        t_status           status;
    } t_result;

    function automatic logic is_ws(input logic [CH_W-1:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: hw/rtl/itlp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itlp_in_if
// byte channel: one text byte and its line start mark per word
// ----------------------------------------------------------------------------
interface itlp_in_if;
    logic                     valid;
    logic                     ready;
    logic [itlp_pkg::CH_W-1:0] ch;
    logic                     first_of_line;

    modport source (output valid, output ch, output first_of_line, input ready);
    modport sink   (input valid, input ch, input first_of_line, output ready);
endinterface

// File: hw/rtl/itlp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itlp_out_if
// result channel: parsed address and status per word
// ----------------------------------------------------------------------------
interface itlp_out_if;
    logic                         valid;
    logic                         ready;
    logic [itlp_pkg::ADDR_W-1:0]  address;
    logic [itlp_pkg::STAT_W-1:0]  status;

    modport source (output valid, output address, output status, input ready);
    modport sink   (input valid, input address, input status, output ready);
endinterface

// File: hw/rtl/itlp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itlp_in_reg
// input register stage of the byte channel
// ----------------------------------------------------------------------------
module itlp_in_reg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [itlp_pkg::CH_W-1:0] i_ch,
    input  logic                     i_first_of_line,
    input  logic                     i_adv,
    output itlp_pkg::t_byte_word     o_word
);
    import itlp_pkg::*;

    logic            r_vld;
    logic [CH_W-1:0] r_ch;
    logic            r_fol;

    // free when empty or when the held word is taken this cycle
    assign o_ready = !r_vld || i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch  <= i_ch;
            r_fol <= i_first_of_line;
        end
    end

    assign o_word.vld           = r_vld;
    assign o_word.ch            = r_ch;
    assign o_word.first_of_line = r_fol;
endmodule

// File: hw/rtl/itlp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itlp_core
// per-byte parse step, line state and result register
// ----------------------------------------------------------------------------
module itlp_core #(
    parameter int MAX_DIGITS = itlp_pkg::MAX_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [itlp_pkg::LEN_W-1:0] i_max_length,
    input  itlp_pkg::t_byte_word       i_word,
    output logic                       o_adv,
    input  logic                       i_out_ready,
    output itlp_pkg::t_result          o_res
);
    import itlp_pkg::*;

    localparam int DC_W = $clog2(MAX_DIGITS + 1);
    localparam logic [DC_W-1:0] DC_MAX = DC_W'(MAX_DIGITS);

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_budget, n_budget;
    logic [DC_W-1:0]    r_dc, n_dc;
    logic [ADDR_W-1:0]  r_acc, n_acc;
    logic [ADDR_W-1:0]  r_part, n_part;
    logic               r_out_vld;
    logic [ADDR_W-1:0]  r_out_addr;
    t_status            r_out_stat;

    logic               take;
    logic               emit;
    t_status            res_stat;
    logic [ADDR_W-1:0]  res_addr;
    logic [LEN_W-1:0]   bud_dec;
    logic [ADDR_W-1:0]  acc_base;
    logic [ADDR_W+3:0]  acc_mul;
    logic [ADDR_W-1:0]  acc_sat;
    logic               in_field;
    logic [CH_W-1:0]    c;

    assign o_adv = !r_out_vld || i_out_ready;
    assign take  = i_word.vld && o_adv;
    assign c     = i_word.ch;

    // field value before this byte; a line start clears it
    assign acc_base = i_word.first_of_line ? '0 : r_acc;

    // accumulate one decimal digit, saturating at all ones
    always_comb begin
        acc_mul = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                + {{(ADDR_W){1'b0}}, c[3:0]};
        acc_sat = (acc_mul[ADDR_W+3:ADDR_W] != 4'b0) ? {ADDR_W{1'b1}}
                                                     : acc_mul[ADDR_W-1:0];
    end

    // parse step on the held byte
    always_comb begin
        n_phase  = r_phase;
        n_budget = r_budget;
        n_dc     = r_dc;
        n_acc    = r_acc;
        n_part   = r_part;
        emit     = 1'b0;
        res_stat = ST_INVALID;
        res_addr = '0;
        in_field = 1'b0;
        bud_dec  = '0;
        if (i_word.first_of_line) begin
            n_phase  = PH_SKIP;
            n_budget = i_max_length;
            n_dc     = '0;
            n_acc    = '0;
            n_part   = '0;
        end
        bud_dec = n_budget - LEN_W'(1);
        unique case (n_phase)
            PH_DONE: begin
            end
            PH_SKIP: begin
                if (n_budget == '0) begin
                    emit     = 1'b1;
                    res_stat = ST_IGNORE;
                end else if (is_ws(c)) begin
                    n_budget = bud_dec;
                    if (bud_dec == '0) begin
                        emit     = 1'b1;
                        res_stat = ST_IGNORE;
                    end
                end else if (c == CH_NUL) begin
                    emit     = 1'b1;
                    res_stat = ST_IGNORE;
                end else begin
                    n_phase  = PH_F1;
                    n_dc     = '0;
                    in_field = 1'b1;
                end
            end
            PH_F1, PH_F2, PH_F3, PH_F4: begin
                in_field = 1'b1;
            end
            default: begin
            end
        endcase

        if (in_field) begin
            if (n_budget == '0) begin
                emit = 1'b1;
            end else if ((n_phase != PH_F4) && (c == CH_DOT)) begin
                if (n_dc == '0) begin
                    emit = 1'b1;
                end else begin
                    // fold finished field into the packed address
                    case (n_phase)
                        PH_F1:   n_part = n_part | (n_acc << SH_F1);
                        PH_F2:   n_part = n_part | (n_acc << SH_F2);
                        default: n_part = n_part | (n_acc << SH_F3);
                    endcase
                    n_phase = t_phase'(n_phase + 3'd1);
                    n_dc    = '0;
                    n_acc   = '0;
                end
            end else if ((n_phase == PH_F4) && ((c == CH_NUL) || is_ws(c))) begin
                emit = 1'b1;
                if (n_dc != '0) begin
                    res_stat = ST_VALID;
                    res_addr = n_part | n_acc;
                end
            end else if ((c < CH_ZERO) || (c > CH_NINE)) begin
                emit = 1'b1;
            end else if (n_dc >= DC_MAX) begin
                emit = 1'b1;
            end else begin
                n_acc    = acc_sat;
                n_dc     = n_dc + DC_W'(1);
                n_budget = bud_dec;
                if (bud_dec == '0) begin
                    emit = 1'b1;
                end
            end
        end

        if (emit) begin
            n_phase = PH_DONE;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DONE;
            r_budget <= '0;
            r_dc     <= '0;
            r_acc    <= '0;
            r_part   <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_budget <= n_budget;
            r_dc     <= n_dc;
            r_acc    <= n_acc;
            r_part   <= n_part;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= take && emit;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out_addr <= res_addr;
            r_out_stat <= res_stat;
        end
    end

    assign o_res.vld     = r_out_vld;
    assign o_res.address = r_out_addr;
    assign o_res.status  = r_out_stat;

`ifndef SYNTHESIS
    // only a valid result carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_stat != ST_VALID)) |-> (r_out_addr == '0))
        else $error("nonzero address on a result that is not valid");

    // a decision closes the line
    a_done_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && emit) |=> (r_phase == PH_DONE) && r_out_vld)
        else $error("line still open after a result");

    // digit count stays within the limit
    a_dc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc <= DC_MAX)
        else $error("digit count above limit");
`endif
endmodule

// File: hw/rtl/ipv4_text_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_text_line_parser
// parses a text line, one byte per word, into a dotted-quad ipv4 address
//
//   channel   dir   word contents
//   i_in      in    ch[7:0], first_of_line
//   o_out     out   address[31:0], status[1:0] (0 valid, 1 invalid, 2 ignore)
//   i_cfg_*   in    max_length[11:0], write when i_cfg_we is high
//
// one byte word is taken every cycle unless the result register stalls;
// the parse step sits between the input register and the result register.
// at most one result word per line.
// the input stays ready while the result register is empty or being taken.
// synchronous active-low reset; max_length resets to 256.
// ----------------------------------------------------------------------------
module ipv4_text_line_parser #(
    parameter int MAX_DIGITS = itlp_pkg::MAX_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    itlp_in_if.sink                    i_in,
    itlp_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [itlp_pkg::LEN_W-1:0] i_cfg_wdata
);
    import itlp_pkg::*;

    logic [LEN_W-1:0] r_max_length;
    t_byte_word       word;
    t_result          res;
    logic             adv;

    // line budget register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    itlp_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_ch            (i_in.ch),
        .i_first_of_line (i_in.first_of_line),
        .i_adv           (adv),
        .o_word          (word)
    );

    itlp_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_word       (word),
        .o_adv        (adv),
        .i_out_ready  (o_out.ready),
        .o_res        (res)
    );

    // result channel
    assign o_out.valid   = res.vld;
    assign o_out.address = res.address;
    assign o_out.status  = res.status;
endmodule
